@@ rtl/string_escape_decoder_assert.svh @@
// Assertion macros shared by the string escape decoder modules.
`ifndef STRING_ESCAPE_DECODER_ASSERT_SVH
`define STRING_ESCAPE_DECODER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SED_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define SED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sed_pkg.sv @@
// Types, constants and helper functions of the string escape decoder.
package sed_pkg;

  // Decoder modes.
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX_HI = 2'd2,
    MODE_HEX_LO = 2'd3
  } mode_t;

  // Character codes.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  // Output queue sizing: one item gives at most two results.
  localparam int MaxResults = 2;
  localparam int QDepth     = 4;
  localparam int PtrW       = $clog2(QDepth);
  localparam int CountW     = $clog2(QDepth + 1);

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       err;
  } result_t;

  // Results of one input item, handed from the decoder to the queue.
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] count;
  } dec_out_t;

  // Value of a hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30 : 8'h39]}) begin
      h.val = c[3:0];
    end else if (c inside {[8'h41 : 8'h46], [8'h61 : 8'h66]}) begin
      h.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // A character result, not yet marked last.
  function automatic result_t make_result(input logic [7:0] c, input logic err);
    result_t r;
    r.data  = c;
    r.valid = 1'b1;
    r.last  = 1'b0;
    r.err   = err;
    return r;
  endfunction

endpackage

@@ rtl/sed_decode.sv @@
// Escape decoder: state registers and the per-item decode logic.
`include "string_escape_decoder_assert.svh"

module sed_decode
  import sed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output dec_out_t   dec
);

  mode_t      mode, mode_next;
  logic [3:0] nibble, nibble_next;
  logic       cr_pending, cr_pending_next;

  result_t    p0, p1;
  logic       p0_v, p1_v;
  hex_digit_t hd;

  // Decode one byte into up to two results and the next state.
  always_comb begin
    mode_next       = mode;
    nibble_next     = nibble;
    cr_pending_next = cr_pending;
    p0_v            = 1'b0;
    p1_v            = 1'b0;
    p0              = make_result(in_byte, 1'b0);
    p1              = make_result(in_byte, 1'b0);
    hd              = hex_digit(in_byte);

    case (mode)
      MODE_NORMAL: begin
        // A held CR goes out first, flagged unless this byte is LF.
        if (cr_pending) begin
          p0_v            = 1'b1;
          p0              = make_result(CH_CR, in_byte != CH_LF);
          cr_pending_next = 1'b0;
        end
        if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESCAPE;
        end else if (in_byte == CH_CR) begin
          if (in_last) begin
            p1_v = 1'b1;
            p1   = make_result(CH_CR, 1'b1);
          end else begin
            cr_pending_next = 1'b1;
          end
        end else begin
          p1_v = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        if (in_byte == CH_X) begin
          mode_next = MODE_HEX_HI;
        end else if (in_byte inside {CH_DQUOTE, CH_SQUOTE, CH_BSLASH}) begin
          p1_v = 1'b1;
        end else if (in_byte == CH_N) begin
          p1_v = 1'b1;
          p1   = make_result(CH_LF, 1'b0);
        end else if (in_byte == CH_T) begin
          p1_v = 1'b1;
          p1   = make_result(CH_TAB, 1'b0);
        end else begin
          // Unknown escape: pass the backslash and the byte.
          p0_v = 1'b1;
          p0   = make_result(CH_BSLASH, 1'b0);
          p1_v = 1'b1;
        end
      end
      MODE_HEX_HI: begin
        if (hd.ok) begin
          nibble_next = hd.val;
          mode_next   = MODE_HEX_LO;
        end else begin
          p1_v      = 1'b1;
          p1        = make_result(in_byte, 1'b1);
          mode_next = MODE_NORMAL;
        end
      end
      MODE_HEX_LO: begin
        p1_v        = 1'b1;
        p1          = hd.ok ? make_result({nibble, hd.val}, 1'b0)
                            : make_result(in_byte, 1'b1);
        nibble_next = 4'd0;
        mode_next   = MODE_NORMAL;
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase

    // Pack the results in order.
    dec.res0  = p0_v ? p0 : p1;
    dec.res1  = p1;
    dec.count = {p0_v & p1_v, p0_v ^ p1_v};

    // The final byte always ends with a result marked last.
    if (in_last) begin
      if (dec.count == 2'd0) begin
        dec.res0.data  = 8'd0;
        dec.res0.valid = 1'b0;
        dec.res0.err   = 1'b0;
        dec.count      = 2'd1;
      end
      if (dec.count == 2'd2) begin
        dec.res1.last = 1'b1;
      end else begin
        dec.res0.last = 1'b1;
      end
      mode_next       = MODE_NORMAL;
      nibble_next     = 4'd0;
      cr_pending_next = 1'b0;
    end
  end

  // State registers, updated on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      nibble     <= 4'd0;
      cr_pending <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      nibble     <= nibble_next;
      cr_pending <= cr_pending_next;
    end
  end

  `SED_ASSERT_ALWAYS(a_cr_only_normal, !cr_pending || mode == MODE_NORMAL, "CR held outside normal mode")
  `SED_ASSERT_NEXT(a_last_resets, fire && in_last, mode == MODE_NORMAL && !cr_pending, "State not cleared after last item")

endmodule

@@ rtl/sed_outq.sv @@
// Result queue: takes up to two results per cycle and gives one per cycle while out_ready is high.
`include "string_escape_decoder_assert.svh"

module sed_outq
  import sed_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dec_out_t dec,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  head
);

  result_t           entries [QDepth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CountW-1:0] count, count_next;
  logic              pop;
  logic [1:0]        push_n;

  // Room for the largest number of results one item can give.
  assign room      = count <= CountW'(QDepth - MaxResults);
  assign out_valid = count != '0;
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign push_n    = push ? dec.count : 2'd0;
  assign count_next = count + CountW'(push_n) - CountW'(pop);

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_n);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count_next;
    end
  end

  // Result storage: the first result at the write pointer, the second after it.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      if (push_n != 2'd0 && PtrW'(i) == wr_ptr) begin
        entries[i] <= dec.res0;
      end
      if (push_n == 2'd2 && PtrW'(i) == wr_ptr + PtrW'(1)) begin
        entries[i] <= dec.res1;
      end
    end
  end

  `SED_ASSERT_ALWAYS(a_no_overflow, count <= CountW'(QDepth), "Result queue overflow")
  `SED_ASSERT_NEXT(a_double_push, push && dec.count == 2'd2 && !pop, count == $past(count) + CountW'(2), "Two results not both queued")

endmodule

@@ rtl/string_escape_decoder.sv @@
// String escape decoder: top level with input handshake and result queue.
// Results are registered in the result queue before they are offered.
// One item per cycle while the queue has room; an item with two results is given out one result at a time.
// Input is taken while the four-entry result queue holds two results or fewer.
// Synchronous reset clears the decode mode, the held CR flag and the queue.
module string_escape_decoder
  import sed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last,
  output logic       lex_error
);

  dec_out_t dec;
  result_t  head;
  logic     room;
  logic     fire;

  // An item is taken when the queue can hold all of its results.
  assign in_ready = room;
  assign fire     = in_valid && in_ready;

  sed_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .dec     (dec)
  );

  sed_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .dec       (dec),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Result fields from the queue head.
  assign out_byte   = head.data;
  assign byte_valid = head.valid;
  assign out_last   = head.last;
  assign lex_error  = head.err;

endmodule
